### sv/rpa_pkg.sv
package rpa_pkg;

    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 7;
    localparam int FFP_W      = 16;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int FILL_W     = $clog2(NUM_PAGES + 1);
    localparam int RNG_W      = ADDR_W + 1 - PAGE_SHIFT;
    localparam int PAGE_SIZE  = 1 << PAGE_SHIFT;
    localparam int LAST_PAGE  = NUM_PAGES - 1;

    localparam logic REG_BASE_ADDRESS    = 1'b0;
    localparam logic REG_FIRST_FREE_PAGE = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RANGE   = 2'd2,
        ACT_INIT    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_BAD_ADDR = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_NONZERO  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WB,
        S_REL_WB,
        S_RANGE,
        S_INIT,
        S_DONE
    } state_t;

endpackage

### sv/rpa_ram.sv
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/refcounted_page_allocator_core.sv
// allocate steps from accepted beat to result: stack read, count read, write-back, output
// release steps: count read, write-back, output; a bad address goes straight to output
// set-range: the pages in the range are written in turn; initialize: all NUM_PAGES pages, one page a cycle
// one item at a time; the next beat is taken in the cycle the previous result appears
// after reset a clearing pass sets every count to one; no beat is taken
// until it ends, configuration writes are taken throughout
module refcounted_page_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [rpa_pkg::ADDR_W-1:0]    address,
    input  logic [rpa_pkg::ADDR_W-1:0]    end_address,
    input  logic [rpa_pkg::CNT_W-1:0]     count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [rpa_pkg::ADDR_W-1:0]    page_address,
    output logic [rpa_pkg::CNT_W-1:0]     count_after
);

    rpa_pkg::state_t                   state_reg, state_next;
    logic [rpa_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [rpa_pkg::IDX_W-1:0]         ptr_reg, ptr_next;
    logic [rpa_pkg::IDX_W-1:0]         end_reg, end_next;
    logic [rpa_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [rpa_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [rpa_pkg::ADDR_W-1:0]        base_reg;
    logic [rpa_pkg::FFP_W-1:0]         ffp_reg;
    rpa_pkg::status_t                  res_status_reg, res_status_next;
    logic [rpa_pkg::ADDR_W-1:0]        res_paddr_reg, res_paddr_next;
    logic [rpa_pkg::CNT_W-1:0]         res_cafter_reg, res_cafter_next;
    logic                              out_valid_reg, out_valid_next;
    logic [2:0]                        out_status_reg;
    logic [rpa_pkg::ADDR_W-1:0]        out_paddr_reg;
    logic [rpa_pkg::CNT_W-1:0]         out_cafter_reg;
    logic                              out_load;

    logic                              cnt_we;
    logic [rpa_pkg::IDX_W-1:0]         cnt_waddr, cnt_raddr;
    logic [rpa_pkg::CNT_W-1:0]         cnt_wdata, cnt_rdata;
    logic                              stk_we;
    logic [rpa_pkg::IDX_W-1:0]         stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic [rpa_pkg::ADDR_W:0]          base33, low33, top33, addr33, s33, e33;
    logic                              rel_bad;
    logic [rpa_pkg::IDX_W-1:0]         rel_idx;
    logic [rpa_pkg::RNG_W-1:0]         i_start, imax_raw, imax;
    logic                              rng_ok;
    logic                              stack_room;
    logic [rpa_pkg::CNT_W-1:0]         dec_cnt;
    logic                              ptr_last;
    logic                              in_free_area;

    rpa_ram #(.WIDTH(rpa_pkg::CNT_W), .DEPTH(rpa_pkg::NUM_PAGES)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rpa_ram #(.WIDTH(rpa_pkg::IDX_W), .DEPTH(rpa_pkg::NUM_PAGES)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // address checks on the incoming beat
    always_comb
    begin
        base33   = {1'b0, base_reg};
        addr33   = {1'b0, address};
        low33    = base33 + ((rpa_pkg::ADDR_W+1)'(ffp_reg) << rpa_pkg::PAGE_SHIFT);
        top33    = base33 + ((rpa_pkg::ADDR_W+1)'(rpa_pkg::NUM_PAGES) << rpa_pkg::PAGE_SHIFT);
        rel_bad  = (address[rpa_pkg::PAGE_SHIFT-1:0] != '0) || (addr33 < low33)
                   || (addr33 >= top33);
        rel_idx  = rpa_pkg::IDX_W'((address - base_reg) >> rpa_pkg::PAGE_SHIFT);
        s33      = {1'b0, address} & ~(rpa_pkg::ADDR_W+1)'(rpa_pkg::PAGE_SIZE - 1);
        e33      = ({1'b0, end_address} + (rpa_pkg::ADDR_W+1)'(rpa_pkg::PAGE_SIZE - 1))
                   & ~(rpa_pkg::ADDR_W+1)'(rpa_pkg::PAGE_SIZE - 1);
        i_start  = (s33 >= base33) ? rpa_pkg::RNG_W'((s33 - base33) >> rpa_pkg::PAGE_SHIFT)
                                   : '0;
        imax_raw = rpa_pkg::RNG_W'((e33 - base33) >> rpa_pkg::PAGE_SHIFT);
        imax     = (imax_raw > rpa_pkg::RNG_W'(rpa_pkg::LAST_PAGE))
                   ? rpa_pkg::RNG_W'(rpa_pkg::LAST_PAGE) : imax_raw;
        rng_ok   = (e33 >= base33) && (i_start <= imax);
    end

    assign stack_room   = fill_reg < rpa_pkg::FILL_W'(rpa_pkg::NUM_PAGES);
    assign dec_cnt      = cnt_rdata - rpa_pkg::CNT_W'(1);
    assign ptr_last     = ptr_reg == rpa_pkg::IDX_W'(rpa_pkg::LAST_PAGE);
    assign in_free_area = {1'b0, ptr_reg} >= (rpa_pkg::IDX_W+1)'(ffp_reg);
    assign out_load     = (state_reg == rpa_pkg::S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_paddr_next  = res_paddr_reg;
        res_cafter_next = res_cafter_reg;
        in_ready        = 1'b0;
        cnt_we          = 1'b0;
        cnt_waddr       = ptr_reg;
        cnt_wdata       = cnt_reg;
        cnt_raddr       = rel_idx;
        stk_we          = 1'b0;
        stk_waddr       = fill_reg[rpa_pkg::IDX_W-1:0];
        stk_wdata       = idx_reg;
        stk_raddr       = rpa_pkg::IDX_W'(fill_reg - rpa_pkg::FILL_W'(1));

        unique case (state_reg)
            rpa_pkg::S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = rpa_pkg::CNT_W'(1);
                ptr_next  = ptr_reg + rpa_pkg::IDX_W'(1);
                if (ptr_last)
                begin
                    state_next = rpa_pkg::S_IDLE;
                end
            end
            rpa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_status_next = rpa_pkg::ST_OK;
                    res_paddr_next  = '0;
                    res_cafter_next = '0;
                    unique case (rpa_pkg::action_t'(action))
                        rpa_pkg::ACT_ALLOC:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = rpa_pkg::ST_OOM;
                                state_next      = rpa_pkg::S_DONE;
                            end
                            else
                            begin
                                fill_next  = fill_reg - rpa_pkg::FILL_W'(1);
                                state_next = rpa_pkg::S_ALLOC_RD;
                            end
                        end
                        rpa_pkg::ACT_RELEASE:
                        begin
                            if (rel_bad)
                            begin
                                res_status_next = rpa_pkg::ST_BAD_ADDR;
                                state_next      = rpa_pkg::S_DONE;
                            end
                            else
                            begin
                                idx_next   = rel_idx;
                                state_next = rpa_pkg::S_REL_WB;
                            end
                        end
                        rpa_pkg::ACT_RANGE:
                        begin
                            if (rng_ok)
                            begin
                                ptr_next   = rpa_pkg::IDX_W'(i_start);
                                end_next   = rpa_pkg::IDX_W'(imax);
                                cnt_next   = count;
                                state_next = rpa_pkg::S_RANGE;
                            end
                            else
                            begin
                                state_next = rpa_pkg::S_DONE;
                            end
                        end
                        rpa_pkg::ACT_INIT:
                        begin
                            ptr_next   = '0;
                            state_next = rpa_pkg::S_INIT;
                        end
                        default:
                        begin
                            state_next = rpa_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rpa_pkg::S_ALLOC_RD:
            begin
                // popped index is on the stack read port
                cnt_raddr  = stk_rdata;
                idx_next   = stk_rdata;
                state_next = rpa_pkg::S_ALLOC_WB;
            end
            rpa_pkg::S_ALLOC_WB:
            begin
                if (cnt_rdata != '0)
                begin
                    res_status_next = rpa_pkg::ST_NONZERO;
                    res_cafter_next = cnt_rdata;
                end
                else
                begin
                    cnt_we          = 1'b1;
                    cnt_waddr       = idx_reg;
                    cnt_wdata       = rpa_pkg::CNT_W'(1);
                    res_cafter_next = rpa_pkg::CNT_W'(1);
                    res_paddr_next  = base_reg
                                      + (rpa_pkg::ADDR_W'(idx_reg) << rpa_pkg::PAGE_SHIFT);
                end
                state_next = rpa_pkg::S_DONE;
            end
            rpa_pkg::S_REL_WB:
            begin
                if (cnt_rdata == '0)
                begin
                    res_status_next = rpa_pkg::ST_DOUBLE;
                end
                else
                begin
                    cnt_we          = 1'b1;
                    cnt_waddr       = idx_reg;
                    cnt_wdata       = dec_cnt;
                    res_cafter_next = dec_cnt;
                    if ((dec_cnt == '0) && stack_room)
                    begin
                        stk_we    = 1'b1;
                        fill_next = fill_reg + rpa_pkg::FILL_W'(1);
                    end
                end
                state_next = rpa_pkg::S_DONE;
            end
            rpa_pkg::S_RANGE:
            begin
                cnt_we   = 1'b1;
                ptr_next = ptr_reg + rpa_pkg::IDX_W'(1);
                if (ptr_reg == end_reg)
                begin
                    res_cafter_next = cnt_reg;
                    state_next      = rpa_pkg::S_DONE;
                end
            end
            rpa_pkg::S_INIT:
            begin
                // pages below the first free page keep a count of one
                cnt_we    = 1'b1;
                cnt_wdata = in_free_area ? '0 : rpa_pkg::CNT_W'(1);
                stk_wdata = ptr_reg;
                if (in_free_area && stack_room)
                begin
                    stk_we    = 1'b1;
                    fill_next = fill_reg + rpa_pkg::FILL_W'(1);
                end
                ptr_next = ptr_reg + rpa_pkg::IDX_W'(1);
                if (ptr_last)
                begin
                    state_next = rpa_pkg::S_DONE;
                end
            end
            rpa_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = rpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpa_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpa_pkg::S_CLEAR;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= 32'h8000_0000;
            ffp_reg       <= rpa_pkg::FFP_W'(256);
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rpa_pkg::REG_BASE_ADDRESS:    base_reg <= cfg_data;
                    rpa_pkg::REG_FIRST_FREE_PAGE: ffp_reg  <= cfg_data[rpa_pkg::FFP_W-1:0];
                    default:                      base_reg <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_paddr_reg  <= res_paddr_next;
        res_cafter_reg <= res_cafter_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_paddr_reg  <= res_paddr_reg;
            out_cafter_reg <= res_cafter_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign page_address = out_paddr_reg;
    assign count_after  = out_cafter_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= rpa_pkg::FILL_W'(rpa_pkg::NUM_PAGES))
        else $error("stack fill beyond depth");

    a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_CLEAR) |-> !in_ready)
        else $error("beat taken during clearing pass");

    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (state_reg == rpa_pkg::S_REL_WB || state_reg == rpa_pkg::S_INIT))
        else $error("stack push outside release or initialize");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |=> (fill_reg == $past(fill_reg) + rpa_pkg::FILL_W'(1)))
        else $error("push without fill increment");

    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_ALLOC_RD) |-> $past(fill_reg) == fill_reg + rpa_pkg::FILL_W'(1))
        else $error("allocate without pop");

endmodule
